>>> hw/rtl/mf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 minimum filter stream unit.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CHAN_N       = 3;
  localparam int unsigned PX_W         = PIX_W * CHAN_N;
  localparam int unsigned CFG_W        = 12;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned HEIGHT_MAX   = 4095;
  localparam int unsigned MIN_DIM      = 3;
  localparam int unsigned DEF_MAX_LINE = 2048;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QCW          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] DEF_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] DEF_HEIGHT = CFG_W'(480);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

  // One classified pixel on its way from the front end to the window stage
  typedef struct packed {
    logic            produce;
    logic            interior;
    logic            last;
    logic [PX_W-1:0] above;
    logic [PX_W-1:0] mid;
    logic [PX_W-1:0] px;
  } mf3_item_t;

endpackage : mf3_pkg
`default_nettype wire

>>> hw/rtl/min_filter_3x3_stream_unit.sv
// While out_stall is low the unit takes one pixel per clock in raster order
// and sustains one pixel per clock at both channels; the line memory (one
// read and one write per cycle) sets that figure. A result passes the line
// memory read register, the queue, the window stage and the output
// register, and results run one row plus one pixel behind the inputs, so
// frame_width+1 drain items must follow each frame; the last result is marked
// with out_frame_end. The line memory holds MAX_LINE entries of 48 bits, is
// never cleared, and its unwritten entries only reach border pixels, which copy
// the centre pixel. Write configuration only while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_filter_3x3_stream_unit
// Streaming 3x3 minimum filter, grayscale or three-channel colour.
// ----------------------------------------------------------------------------
module min_filter_3x3_stream_unit #(
  parameter int unsigned MAX_LINE = mf3_pkg::DEF_MAX_LINE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mf3_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mf3_pkg::PIX_W-1:0]     in_chan0,
  input  wire logic [mf3_pkg::PIX_W-1:0]     in_chan1,
  input  wire logic [mf3_pkg::PIX_W-1:0]     in_chan2,
  input  wire logic                          in_drain,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mf3_pkg::PIX_W-1:0]          out_chan0,
  output logic [mf3_pkg::PIX_W-1:0]          out_chan1,
  output logic [mf3_pkg::PIX_W-1:0]          out_chan2,
  output logic                               out_frame_end
);
  import mf3_pkg::*;

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic             color_mode_r;
  logic             item_valid, q_valid, q_pop;
  mf3_item_t        item, q_item;
  logic [QCW-1:0]   q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DEF_WIDTH;
      frame_height_r <= DEF_HEIGHT;
      color_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_COLOR_MODE:   color_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mf3_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_chan0     (in_chan0),
    .in_chan1     (in_chan1),
    .in_chan2     (in_chan2),
    .in_drain     (in_drain),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_count      (q_count),
    .item_valid   (item_valid),
    .item         (item)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_valid),
    .push_item (item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_count   (q_count)
  );

  mf3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .color_mode    (color_mode_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_chan0     (out_chan0),
    .out_chan1     (out_chan1),
    .out_chan2     (out_chan2),
    .out_frame_end (out_frame_end)
  );

endmodule : min_filter_3x3_stream_unit
`default_nettype wire

>>> hw/rtl/mf3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_front
// Front end: takes pixels, tracks the raster position, classifies each pixel
// and reads and updates the two line stores held in one line memory.
// ----------------------------------------------------------------------------
module mf3_front #(
  parameter int unsigned MAX_LINE = mf3_pkg::DEF_MAX_LINE
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mf3_pkg::PIX_W-1:0]   in_chan0,
  input  wire logic [mf3_pkg::PIX_W-1:0]   in_chan1,
  input  wire logic [mf3_pkg::PIX_W-1:0]   in_chan2,
  input  wire logic                        in_drain,
  input  wire logic [mf3_pkg::CFG_W-1:0]   frame_width,
  input  wire logic [mf3_pkg::CFG_W-1:0]   frame_height,
  input  wire logic [mf3_pkg::QCW-1:0]     q_count,
  output logic                             item_valid,
  output mf3_pkg::mf3_item_t               item
);
  import mf3_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned WW = $clog2(MAX_LINE + 1);
  localparam int unsigned PW = WW + ROW_W;

  logic [AW-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PW-1:0]     emit_r, emit_nxt;
  logic [PW-1:0]     frame_px_r;
  logic [WW-1:0]     w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic              accept;
  logic              produce, interior, last, wrap;
  logic [PX_W-1:0]   px;

  // Line memory: upper half holds the row two above, lower half the row above
  logic [2*PX_W-1:0] line_mem [0:MAX_LINE-1];
  logic [2*PX_W-1:0] rd_r;

  logic              s1_valid_r;
  logic [AW-1:0]     s1_idx_r;
  logic [PX_W-1:0]   s1_px_r;
  logic              s1_produce_r, s1_interior_r, s1_last_r;

  always_comb begin
    if (32'(frame_width) < MIN_DIM) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(frame_width) > MAX_LINE) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (32'(frame_height) < MIN_DIM) begin
      h_eff = ROW_W'(MIN_DIM);
    end else begin
      h_eff = frame_height;
    end
  end

  // Credit check: the queue must have room for this transfer and the one in flight.
  assign in_stall = (32'(q_count) + 32'(s1_valid_r)) >= QUEUE_DEPTH;
  assign accept   = in_valid && !in_stall;
  assign px       = in_drain ? '0 : {in_chan2, in_chan1, in_chan0};

  always_comb begin
    produce  = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    interior = (col_r >= AW'(2)) && ((32'(col_r) + 1) <= 32'(w_eff))
            && (row_r >= ROW_W'(2)) && ((32'(row_r) + 1) <= 32'(h_eff));
    last     = (32'(emit_r) + 1) >= 32'(frame_px_r);
    wrap     = (32'(col_r) + 1) >= 32'(w_eff);

    col_nxt  = col_r;
    row_nxt  = row_r;
    emit_nxt = emit_r;
    if (accept) begin
      if (wrap) begin
        col_nxt = '0;
        if (32'(row_r) < HEIGHT_MAX) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
      if (produce) begin
        if (last) begin
          col_nxt  = '0;
          row_nxt  = '0;
          emit_nxt = '0;
        end else begin
          emit_nxt = emit_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      emit_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      emit_r     <= emit_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    frame_px_r <= PW'(w_eff) * PW'(h_eff);
    if (accept) begin
      s1_idx_r      <= col_r;
      s1_px_r       <= px;
      s1_produce_r  <= produce;
      s1_interior_r <= interior;
      s1_last_r     <= last;
    end
  end

  // Within a frame the same entry is next read at least three transfers later, after this write.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_valid_r) begin
      line_mem[s1_idx_r] <= {rd_r[PX_W-1:0], s1_px_r};
    end
  end

  assign item_valid    = s1_valid_r;
  assign item.produce  = s1_produce_r;
  assign item.interior = s1_interior_r;
  assign item.last     = s1_last_r;
  assign item.above    = rd_r[2*PX_W-1:PX_W];
  assign item.mid      = rd_r[PX_W-1:0];
  assign item.px       = s1_px_r;

endmodule : mf3_front
`default_nettype wire

>>> hw/rtl/mf3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_queue
// Short queue of classified pixels between the front end and the window stage.
// ----------------------------------------------------------------------------
module mf3_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire mf3_pkg::mf3_item_t      push_item,
  input  wire logic                    pop,
  output logic                         q_valid,
  output mf3_pkg::mf3_item_t           q_item,
  output logic [mf3_pkg::QCW-1:0]      q_count
);
  import mf3_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  mf3_item_t         slot_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]    count_r;
  logic              do_pop;

  assign q_valid = count_r != '0;
  assign do_pop  = pop && q_valid;
  assign q_item  = slot_r[rd_ptr_r];
  assign q_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : mf3_queue
`default_nettype wire

>>> hw/rtl/mf3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_back
// Back end: shifts the 3x3 window, takes the per-channel minimum (the centre
// pixel at the border) and holds the result in the output register.
// ----------------------------------------------------------------------------
module mf3_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire mf3_pkg::mf3_item_t          q_item,
  output logic                             q_pop,
  input  wire logic                        color_mode,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mf3_pkg::PIX_W-1:0]        out_chan0,
  output logic [mf3_pkg::PIX_W-1:0]        out_chan1,
  output logic [mf3_pkg::PIX_W-1:0]        out_chan2,
  output logic                             out_frame_end
);
  import mf3_pkg::*;

  logic [PX_W-1:0]  win_r [0:2][0:2];
  logic             a_valid_r, a_interior_r, a_last_r;
  logic             a_adv;
  logic             out_valid_r, out_fe_r;
  logic [PX_W-1:0]  out_px_r;
  logic [PX_W-1:0]  res;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign a_adv = a_valid_r && (!out_valid_r || !out_stall);
  // Every queued pixel shifts the window, whether or not it yields a result.
  assign q_pop = q_valid && (!a_valid_r || a_adv);

  always_comb begin
    logic [PIX_W-1:0] m;
    res = '0;
    for (int k = 0; k < CHAN_N; k++) begin
      m = win_r[0][0][k*PIX_W +: PIX_W];
      for (int j = 1; j < 9; j++) begin
        m = min2(m, win_r[j / 3][j % 3][k*PIX_W +: PIX_W]);
      end
      if (a_interior_r) begin
        res[k*PIX_W +: PIX_W] = m;
      end else begin
        res[k*PIX_W +: PIX_W] = win_r[1][1][k*PIX_W +: PIX_W];
      end
      if (!color_mode && k != 0) begin
        res[k*PIX_W +: PIX_W] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid_r <= q_item.produce;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2]  <= q_item.above;
      win_r[1][2]  <= q_item.mid;
      win_r[2][2]  <= q_item.px;
      a_interior_r <= q_item.interior;
      a_last_r     <= q_item.last;
    end
    if (a_adv) begin
      out_px_r <= res;
      out_fe_r <= a_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_chan0     = out_px_r[PIX_W-1:0];
  assign out_chan1     = out_px_r[2*PIX_W-1:PIX_W];
  assign out_chan2     = out_px_r[3*PIX_W-1:2*PIX_W];
  assign out_frame_end = out_fe_r;

endmodule : mf3_back
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 minimum filter. A predictor of
// the line stores, window and frame counters runs on every input transfer
// and queues the expected pixels. Each output transfer is compared with the
// oldest entry. Stimulus is a default-width frame of height 3 after reset,
// two hand-written 3x3 frames, the size extremes, and then random small
// frames with noise, back-to-back frames and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import mf3_pkg::*;

  localparam int unsigned MAX_LINE      = DEF_MAX_LINE;
  localparam int unsigned RAND_ITEMS    = 1650;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned WDOG_LIMIT    = 4000;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] ch0;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch2;
    logic             fe;
  } min_res_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] c0;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c2;
    logic             drain;
    logic             typed;
    logic             has_res;
    min_res_t         want;
  } dir_row_t;

  localparam min_res_t NO_RES = '0;

  // Two 3x3 frames, colour then grayscale. Results lag four transfers, so row
  // k carries the expectation for pixel k-4. The centre pixel of the first
  // frame is left to the predictor.
  localparam dir_row_t DIR_TAB [26] = '{
    '{1'b1, 8'h10, 8'hFF, 8'h20, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, 8'hFF, 8'h08, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, 8'h80, 8'h81, 8'h82, 1'b0, 1'b1, 1'b1, '{8'h10, 8'hFF, 8'h20, 1'b0}},
    '{1'b1, 8'h40, 8'h50, 8'h60, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'h08, 8'hFF, 1'b0}},
    '{1'b1, 8'h01, 8'h02, 8'h03, 1'b0, 1'b1, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
    '{1'b1, 8'hFE, 8'hFD, 8'hFC, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{1'b1, 8'hC0, 8'hC1, 8'hC2, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, 8'hAA, 8'hBB, 8'hCC, 1'b0, 1'b1, 1'b1, '{8'h40, 8'h50, 8'h60, 1'b0}},
    '{1'b1, 8'h55, 8'h66, 8'h77, 1'b0, 1'b1, 1'b1, '{8'h01, 8'h02, 8'h03, 1'b0}},
    '{1'b1, 8'h33, 8'h44, 8'h55, 1'b1, 1'b1, 1'b1, '{8'hFE, 8'hFD, 8'hFC, 1'b0}},
    '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, '{8'hC0, 8'hC1, 8'hC2, 1'b1}},
    '{1'b0, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'h7F, 8'h80, 8'h81, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'h01, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'h99, 8'h99, 8'h99, 1'b1, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h02, 8'h10, 8'h20, 1'b0, 1'b1, 1'b1, '{8'h7F, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h03, 8'h30, 8'h40, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h04, 8'h50, 8'h60, 1'b0, 1'b1, 1'b1, '{8'h01, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h05, 8'h70, 8'h80, 1'b0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h11, 8'h22, 8'h33, 1'b1, 1'b1, 1'b1, '{8'h02, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h44, 8'h55, 8'h66, 1'b0, 1'b1, 1'b1, '{8'h03, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h77, 8'h88, 8'h99, 1'b0, 1'b1, 1'b1, '{8'h04, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'hFE, 8'hEE, 8'hDE, 1'b1, 1'b1, 1'b1, '{8'h05, 8'h00, 8'h00, 1'b1}}
  };

  localparam logic [CFG_W-1:0] EXT_W [4] = '{12'd4095, 12'd3, 12'd2048, 12'd0};
  localparam logic [CFG_W-1:0] EXT_H [4] = '{12'd2, 12'd4095, 12'd3, 12'd1};
  localparam logic             EXT_C [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_chan0;
  logic [PIX_W-1:0]     in_chan1;
  logic [PIX_W-1:0]     in_chan2;
  logic                 in_drain;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_chan0;
  logic [PIX_W-1:0]     out_chan1;
  logic [PIX_W-1:0]     out_chan2;
  logic                 out_frame_end;

  // Predictor state
  bit [CFG_W-1:0] width_reg  = DEF_WIDTH;
  bit [CFG_W-1:0] height_reg = DEF_HEIGHT;
  bit             color_reg  = 1'b0;
  bit [PX_W-1:0]  upper_line [MAX_LINE];
  bit [PX_W-1:0]  middle_line [MAX_LINE];
  bit [PX_W-1:0]  win [3][3];
  int unsigned    col_pos     = 0;
  int unsigned    row_pos     = 0;
  int unsigned    emitted_cnt = 0;

  min_res_t    expected_min_q [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned tx_pct         = 15;
  int unsigned rx_pct         = 25;
  bit          calm           = 1'b0;
  bit          hold_req       = 1'b0;

  min_filter_3x3_stream_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_chan0      (in_chan0),
    .in_chan1      (in_chan1),
    .in_chan2      (in_chan2),
    .in_drain      (in_drain),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_chan0     (out_chan0),
    .out_chan1     (out_chan1),
    .out_chan2     (out_chan2),
    .out_frame_end (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, lo, hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] rand_level();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // Advances the window and counters by one pixel and works out the pixel,
  // if any, that the block gives for it.
  task automatic predict_min(input logic [PIX_W-1:0] c0, c1, c2, input logic drain,
                             output bit has_res, output min_res_t res);
    int unsigned      w, h, c, r, idx, cr, cc;
    bit [PX_W-1:0]    px, above, midv, centre;
    bit               interior;
    logic [PIX_W-1:0] v, m, t;
    logic [PIX_W-1:0] chan_out [3];
    w = clamp_dim(width_reg, MIN_DIM, MAX_LINE);
    h = clamp_dim(height_reg, MIN_DIM, HEIGHT_MAX);
    c = col_pos;
    r = row_pos;
    idx = (c < MAX_LINE) ? c : MAX_LINE - 1;
    px = drain ? '0 : {c2, c1, c0};
    above = upper_line[idx];
    midv = middle_line[idx];
    upper_line[idx] = midv;
    middle_line[idx] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above;
    win[1][2] = midv;
    win[2][2] = px;
    has_res = (r >= 2) || (r == 1 && c >= 1);
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < HEIGHT_MAX) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    res = NO_RES;
    if (has_res) begin
      // The centre of the window sits one row and one column behind the input.
      if (c >= 1) begin
        cr = r - 1;
        cc = c - 1;
      end else begin
        cr = r - 2;
        cc = w - 1;
      end
      interior = cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w;
      centre = win[1][1];
      for (int k = 0; k < 3; k++) begin
        v = centre[8*k +: 8];
        if (interior) begin
          m = 8'hFF;
          for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
              t = win[a][b][8*k +: 8];
              if (t < m) m = t;
            end
          end
          v = m;
        end
        if (!color_reg && k != 0) v = 8'h00;
        chan_out[k] = v;
      end
      res.ch0 = chan_out[0];
      res.ch1 = chan_out[1];
      res.ch2 = chan_out[2];
      res.fe = (emitted_cnt + 1 >= w * h);
      if (res.fe) begin
        col_pos = 0;
        row_pos = 0;
        emitted_cnt = 0;
      end else begin
        emitted_cnt++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_COLOR_MODE: color_reg = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Returns at the edge on which the pixel is transferred; valid stays high.
  task automatic send_px(input logic [PIX_W-1:0] c0, c1, c2, input logic drain);
    if (!calm && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chan0 <= c0;
    in_chan1 <= c1;
    in_chan2 <= c2;
    in_drain <= drain;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed_px(input logic [PIX_W-1:0] c0, c1, c2, input logic drain);
    bit       has;
    min_res_t res;
    send_px(c0, c1, c2, drain);
    predict_min(c0, c1, c2, drain, has, res);
    if (has) expected_min_q.push_back(res);
    items_sent++;
  endtask

  // Waits until every queued pixel has come out and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_min_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setup(input logic [CFG_W-1:0] w, h, input logic color);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_COLOR_MODE, {11'($urandom), color});
    write_reg(REG_UNUSED, 12'($urandom));
  endtask

  // Sends whole frames under the current settings. Between frames the tail
  // flush is sometimes left out, so the next frame's pixels flush the tail.
  task automatic send_frames(input int unsigned frames);
    int unsigned w, h;
    w = clamp_dim(width_reg, MIN_DIM, MAX_LINE);
    h = clamp_dim(height_reg, MIN_DIM, HEIGHT_MAX);
    for (int unsigned f = 0; f < frames; f++) begin
      for (int unsigned p = 0; p < w * h; p++)
        feed_px(rand_level(), rand_level(), rand_level(), $urandom_range(0, 99) < 3);
      if (f + 1 == frames || $urandom_range(0, 99) >= 35) begin
        while (col_pos != 0 || row_pos != 0 || emitted_cnt != 0)
          feed_px(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 99) < 80);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [PIX_W-1:0] want, got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    min_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_min_q.size() == 0) begin
        $error("output transfer with no pixel expected");
        mismatch_count++;
      end else begin
        want = expected_min_q.pop_front();
        check_field("out_chan0", want.ch0, out_chan0);
        check_field("out_chan1", want.ch1, out_chan1);
        check_field("out_chan2", want.ch2, out_chan2);
        check_field("out_frame_end", {7'd0, want.fe}, {7'd0, out_frame_end});
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin : rx_side
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;
    bit          stall_next = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall_next = 1'b1;
      end else if (calm) begin
        stall_next = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        if ($urandom_range(0, 31) == 0) begin
          case ($urandom_range(0, 2))
            0: rx_pct = 0;
            1: rx_pct = 20;
            default: rx_pct = 50;
          endcase
        end
        stall_next = $urandom_range(0, 99) < rx_pct;
        burst_left = $urandom_range(0, 11);
      end
      out_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    bit          has;
    min_res_t    res;
    int unsigned start;
    logic [CFG_W-1:0] w_sel, h_sel;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_chan0 <= '0;
    in_chan1 <= '0;
    in_chan2 <= '0;
    in_drain <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width and grayscale mode, with only the height shortened.
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    send_frames(1);

    for (int i = 0; i < 26; i++) begin
      if (i % 13 == 0) apply_setup(12'd3, 12'd3, DIR_TAB[i].mode);
      send_px(DIR_TAB[i].c0, DIR_TAB[i].c1, DIR_TAB[i].c2, DIR_TAB[i].drain);
      predict_min(DIR_TAB[i].c0, DIR_TAB[i].c1, DIR_TAB[i].c2, DIR_TAB[i].drain, has, res);
      if (DIR_TAB[i].typed) begin
        has = DIR_TAB[i].has_res;
        res = DIR_TAB[i].want;
      end
      if (has) expected_min_q.push_back(res);
    end

    for (int i = 0; i < 4; i++) begin
      apply_setup(EXT_W[i], EXT_H[i], EXT_C[i]);
      send_frames(1);
    end

    // The receiver holds off while the sender keeps offering pixels.
    hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      if (items_sent - start > RAND_ITEMS - 250) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: w_sel = 12'($urandom_range(0, 2));
        1: w_sel = 12'($urandom_range(11, 48));
        default: w_sel = 12'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 9))
        0: h_sel = 12'($urandom_range(0, 2));
        1: h_sel = 12'($urandom_range(7, 12));
        default: h_sel = 12'($urandom_range(3, 6));
      endcase
      case ($urandom_range(0, 2))
        0: tx_pct = 0;
        1: tx_pct = 10;
        default: tx_pct = 35;
      endcase
      apply_setup(w_sel, h_sel, 1'($urandom_range(0, 1)));
      send_frames($urandom_range(1, 3));
    end

    settle();
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : tb_top
